>>> rtl/sorted_key_table_search_insert_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted key table
// Clocked on clk, quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_SEARCH_INSERT_ASSERT_SVH
`define SORTED_KEY_TABLE_SEARCH_INSERT_ASSERT_SVH

// Same-cycle implication
`define SKTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SKTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/skts_pkg.sv
// ---------------------------------------------------------------------------
// skts_pkg
// Shared constants and types of the sorted key table.
// ---------------------------------------------------------------------------
`default_nettype none

package skts_pkg;

    localparam int CAPACITY = 512;
    localparam int KEY_W    = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FIELD_W  = 10;
    localparam int STATUS_W = 3;

    // cells are summarized in groups of GROUP_SZ
    localparam int GROUP_SZ = 32;
    localparam int GROUP_W  = $clog2(GROUP_SZ);
    localparam int NGROUPS  = (CAPACITY + GROUP_SZ - 1) / GROUP_SZ;
    localparam int NCELLS   = NGROUPS * GROUP_SZ;
    localparam int POS_W    = $clog2(NCELLS + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_INSERTED = 3'd2,
        ST_PRESENT  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // broadcast to every cell
    typedef struct packed {
        logic             cmp;   // compare stored key against key
        logic             ins;   // shift up and insert key
        logic [KEY_W-1:0] key;
    } cell_ctl_t;

    // summary of one group of cells
    typedef struct packed {
        logic               all_lt;  // every cell holds a smaller key
        logic               any_eq;  // one cell holds the key
        logic [GROUP_W-1:0] first;   // local index of the first cell not smaller
    } grp_sum_t;

endpackage

`default_nettype wire

>>> rtl/skts_cell.sv
// ---------------------------------------------------------------------------
// skts_cell
// One table slot: holds a key, compares it with the search key and takes
// its left neighbor's key (or the new key) during an insert.
// ---------------------------------------------------------------------------
`default_nettype none

module skts_cell
    import skts_pkg::*;
(
    input  wire logic             clk,
    input  wire cell_ctl_t        ctl,
    input  wire logic             valid,     // slot index below the count
    input  wire logic [KEY_W-1:0] left_key,
    input  wire logic             left_ge,
    output logic      [KEY_W-1:0] key,
    output logic                  ge,
    output logic                  eq
);

    logic [KEY_W-1:0] key_reg;
    logic             lt_reg;
    logic             eq_reg;

    // compare flags, captured once per item
    always_ff @(posedge clk)
    begin
        if (ctl.cmp)
        begin
            lt_reg <= valid && (key_reg < ctl.key);
            eq_reg <= valid && (key_reg == ctl.key);
        end
    end

    // insert: the first slot not smaller takes the new key, higher slots shift up
    always_ff @(posedge clk)
    begin
        if (ctl.ins && !lt_reg)
        begin
            if (left_ge)
                key_reg <= left_key;
            else
                key_reg <= ctl.key;
        end
    end

    assign key = key_reg;
    assign ge  = !lt_reg;
    assign eq  = eq_reg;

endmodule

`default_nettype wire

>>> rtl/skts_chain.sv
// ---------------------------------------------------------------------------
// skts_chain
// Row of key cells with a registered per-group summary of their flags.
// ---------------------------------------------------------------------------
`default_nettype none

module skts_chain
    import skts_pkg::*;
(
    input  wire logic                    clk,
    input  wire cell_ctl_t               ctl,
    input  wire logic [CNT_W-1:0]        count,
    output grp_sum_t  [NGROUPS-1:0]      sum
);

    logic [KEY_W-1:0] key_w [CAPACITY];
    logic [NCELLS-1:0] ge_w;
    logic [NCELLS-1:0] eq_w;
    logic [NCELLS:0]   ge_ext;     // ge shifted up, cell below index 0 counts as smaller
    grp_sum_t [NGROUPS-1:0] sum_next;
    grp_sum_t [NGROUPS-1:0] sum_reg;

    // cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_W-1:0] lkey;
        logic             lge;
        logic             valid;

        if (i == 0)
        begin : g_first
            assign lkey = ctl.key;
            assign lge  = 1'b0;
        end
        else
        begin : g_rest
            assign lkey = key_w[i-1];
            assign lge  = ge_w[i-1];
        end

        assign valid = (CNT_W'(i) < count);

        skts_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .valid    (valid),
            .left_key (lkey),
            .left_ge  (lge),
            .key      (key_w[i]),
            .ge       (ge_w[i]),
            .eq       (eq_w[i])
        );
    end

    // padding slots above capacity read as empty
    for (genvar i = CAPACITY; i < NCELLS; i++)
    begin : g_pad
        assign ge_w[i] = 1'b1;
        assign eq_w[i] = 1'b0;
    end

    assign ge_ext = {ge_w, 1'b0};

    // group summary
    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            sum_next[g].all_lt = ~|ge_w[g*GROUP_SZ +: GROUP_SZ];
            sum_next[g].any_eq = |eq_w[g*GROUP_SZ +: GROUP_SZ];
            sum_next[g].first  = '0;
            for (int j = 0; j < GROUP_SZ; j++)
            begin
                if (ge_w[g*GROUP_SZ + j] && !ge_ext[g*GROUP_SZ + j])
                    sum_next[g].first = sum_next[g].first | GROUP_W'(j);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

>>> rtl/sorted_key_table_search_insert.sv
// Path from the input beat to the result beat: compare in the cells,
//   group summary, final select, output register.
// The next beat is taken only after the previous result is registered.
// Insert shifts all higher keys one place at once across the cell row.
// Reset: asynchronous, clears the entry count and the handshake state; stored
//   keys are not cleared and are never read above the count.
// ---------------------------------------------------------------------------
// sorted_key_table_search_insert
// Ascending table of 16-bit keys with lookup and ordered insert, built as a
// row of compare-and-shift cells.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_table_search_insert_assert.svh"

module sorted_key_table_search_insert
    import skts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] key
    input  wire logic [0:0]  s_tuser,   // [0] operation (0 lookup, 1 insert)
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata    // [2:0] status, [12:3] position,
                                        // [22:13] entry_count, [23] zero
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_RED  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [KEY_W-1:0]   key_reg;
    logic               op_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               m_tvalid_reg;
    logic [23:0]        m_tdata_reg;

    cell_ctl_t              ctl;
    grp_sum_t [NGROUPS-1:0] sum;
    logic [NGROUPS:0]       prev_all_lt;
    logic [POS_W-1:0]       pos;
    logic                   hit;
    logic                   full;
    logic                   do_insert;
    logic                   out_free;
    logic                   finish;
    status_t                status;

    skts_chain u_chain (
        .clk   (clk),
        .ctl   (ctl),
        .count (count_reg),
        .sum   (sum)
    );

    // final select over the group summaries
    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
            prev_all_lt[g+1] = sum[g].all_lt;
        prev_all_lt[0] = 1'b1;
        pos = '0;
        hit = 1'b0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            if (!sum[g].all_lt && prev_all_lt[g])
            begin
                pos = pos | POS_W'(g * GROUP_SZ) | POS_W'(sum[g].first);
                hit = hit | sum[g].any_eq;
            end
        end
        if (sum[NGROUPS-1].all_lt)
            pos = POS_W'(NCELLS);
    end

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign do_insert = op_reg && !hit && !full;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign finish    = (state_reg == S_FIN) && out_free;

    always_comb
    begin
        priority if (!op_reg)
            status = hit ? ST_FOUND : ST_NOTFOUND;
        else if (hit)
            status = ST_PRESENT;
        else if (full)
            status = ST_FULL;
        else
            status = ST_INSERTED;
    end

    // cell controls
    assign ctl.cmp = (state_reg == S_CMP);
    assign ctl.ins = finish && do_insert;
    assign ctl.key = key_reg;

    assign count_next = ctl.ins ? count_reg + CNT_W'(1) : count_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_CMP;
            S_CMP:  state_next = S_RED;
            S_RED:  state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (finish)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // input beat capture and result register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            key_reg <= s_tdata;
            op_reg  <= s_tuser[0];
        end
        if (finish)
            m_tdata_reg <= {1'b0, FIELD_W'(count_next), FIELD_W'(pos), status};
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SKTS_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CNT_W'(CAPACITY),
        "entry count above capacity")
    `SKTS_ASSERT_NOW(a_ins_not_full, ctl.ins, !full && !hit,
        "insert issued on a full table or a present key")
    `SKTS_ASSERT_NEXT(a_ins_count, ctl.ins, count_reg == $past(count_reg) + CNT_W'(1),
        "count did not advance after insert")
    `SKTS_ASSERT_NEXT(a_accept_cmp, s_tvalid && s_tready, state_reg == S_CMP && !s_tready,
        "accepted beat did not start a compare")

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// Sorted key table testbench
// Sends lookup and insert beats to the key table and compares each result
// beat with the answer of an in-bench copy of the table. A short directed
// run covers empty-table lookups and keys at both ends of the range. A random
// run then fills the table to capacity and keeps working it while it is full.
// Both stream sides idle in random bursts, and once the receiver holds off
// long enough for the block to stall its input.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import skts_pkg::*;

    localparam bit OP_LOOKUP = 1'b0;
    localparam bit OP_INSERT = 1'b1;

    localparam int ITEMS_TOTAL = 1550;
    localparam int CALM_TAIL   = 150;     // last beats run with no idling
    localparam int HOLD_AT     = 400;     // results seen before the long hold
    localparam int HOLD_LEN    = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 16;

    typedef struct packed {
        bit          op;
        logic [15:0] key;
    } key_request_t;

    typedef struct packed {
        status_t     status;
        logic [9:0]  position;
        logic [9:0]  entry_count;
    } table_answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;       // [15:0] key
    logic [0:0]  s_tuser = '0;       // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [2:0] status, [12:3] position,
                                     // [22:13] entry_count, [23] zero

    sorted_key_table_search_insert uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    key_request_t  key_requests[$];
    table_answer_t lookup_answers[$];

    // shadow of the table contents
    logic [15:0] key_row [CAPACITY];
    int unsigned key_count = 0;

    // keys the generator has already sent for insert
    bit          gen_has [bit [15:0]];
    logic [15:0] gen_keys[$];

    bit          in_fire = 1'b0;
    int          fail_count = 0;
    int          results_seen = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          cycles = 0;

    // binary search, then insert with shift-up when the key is new and the table is not full
    function automatic table_answer_t search_and_insert(key_request_t req);
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   mid;
        int unsigned   i;
        bit            hit;
        table_answer_t ans;
        lo  = 0;
        hi  = key_count;
        hit = 1'b0;
        while (lo < hi && !hit)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (key_row[mid] == req.key)
            begin
                hit = 1'b1;
                lo  = mid;
            end
            else if (key_row[mid] < req.key)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (req.op == OP_LOOKUP)
            ans.status = hit ? ST_FOUND : ST_NOTFOUND;
        else if (hit)
            ans.status = ST_PRESENT;
        else if (key_count >= CAPACITY)
            ans.status = ST_FULL;
        else
        begin
            for (i = key_count; i > lo; i--)
                key_row[i] = key_row[i - 1];
            key_row[lo] = req.key;
            key_count++;
            ans.status = ST_INSERTED;
        end
        ans.position    = 10'(lo);
        ans.entry_count = 10'(key_count);
        return ans;
    endfunction

    task automatic add_request(bit op, logic [15:0] key);
        key_requests.push_back('{op: op, key: key});
        if (op == OP_INSERT && !gen_has.exists(key) && gen_keys.size() < CAPACITY)
        begin
            gen_has[key] = 1'b1;
            gen_keys.push_back(key);
        end
    endtask

    function automatic logic [15:0] some_held_key();
        if (gen_keys.size() == 0)
            return 16'($urandom);
        return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
    endfunction

    // result check first, then prediction for the beat taken at this edge
    always @(posedge clk)
    begin : check_results
        table_answer_t got;
        table_answer_t want;
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got.status      = status_t'(m_tdata[2:0]);
            got.position    = m_tdata[12:3];
            got.entry_count = m_tdata[22:13];
            if (lookup_answers.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result beat: status %0d position %0d count %0d",
                             got.status, got.position, got.entry_count);
            end
            else
            begin
                want = lookup_answers.pop_front();
                if (got.status != want.status || got.position != want.position ||
                    got.entry_count != want.entry_count)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: status %0d/%0d position %0d/%0d count %0d/%0d (exp/got)",
                                 want.status, got.status, want.position, got.position,
                                 want.entry_count, got.entry_count);
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
            lookup_answers.push_back(search_and_insert('{op: s_tuser[0], key: s_tdata}));
    end

    // input side: new beat after each accept, random idle bursts
    always @(negedge clk)
    begin : feed_requests
        key_request_t req;
        bit           offer;
        if (rst_n && (!s_tvalid || in_fire))
        begin
            offer = 1'b0;
            if (src_gap != 0)
                src_gap--;
            else if (key_requests.size() == 0)
                offer = 1'b0;
            else if (key_requests.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                src_gap = $urandom_range(1, 8) - 1;
            else
            begin
                req = key_requests.pop_front();
                s_tdata  <= req.key;
                s_tuser  <= req.op;
                offer    = 1'b1;
            end
            s_tvalid <= offer;
        end
    end

    // long receiver hold-off, once
    always @(negedge clk)
    begin
        if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // output side: random stall bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
                m_tready <= 1'b0;
            else if (sink_gap != 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else if (key_requests.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int pick;

        // empty table, then keys at both ends and in the middle
        add_request(OP_LOOKUP, 16'h0000);
        add_request(OP_LOOKUP, 16'hFFFF);
        add_request(OP_INSERT, 16'h8000);
        add_request(OP_INSERT, 16'h0000);
        add_request(OP_INSERT, 16'hFFFF);
        add_request(OP_INSERT, 16'h00FF);
        add_request(OP_INSERT, 16'hFF00);
        add_request(OP_INSERT, 16'h0100);
        add_request(OP_INSERT, 16'h7FFF);
        add_request(OP_INSERT, 16'h8000);
        add_request(OP_INSERT, 16'h0000);
        add_request(OP_INSERT, 16'hFFFF);
        add_request(OP_LOOKUP, 16'h0000);
        add_request(OP_LOOKUP, 16'hFFFF);
        add_request(OP_LOOKUP, 16'h8001);
        add_request(OP_LOOKUP, 16'h00FE);
        add_request(OP_LOOKUP, 16'h7FFF);
        add_request(OP_LOOKUP, 16'hFFFE);

        // fill up to capacity with mixed traffic
        while (gen_keys.size() < CAPACITY)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                add_request(OP_INSERT, 16'($urandom));
            else if (pick < 70)
                add_request(OP_INSERT, some_held_key());
            else if (pick < 85)
                add_request(OP_LOOKUP, some_held_key());
            else if (pick < 92)
                add_request(OP_LOOKUP, some_held_key() ^ 16'h0001);
            else
                add_request(OP_LOOKUP, 16'($urandom));
        end

        // full table: held keys come back present, new ones report full
        while (key_requests.size() < ITEMS_TOTAL)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                add_request(OP_INSERT, some_held_key());
            else if (pick < 60)
                add_request(OP_INSERT, 16'($urandom));
            else if (pick < 80)
                add_request(OP_LOOKUP, some_held_key());
            else if (pick < 90)
                add_request(OP_LOOKUP, some_held_key() ^ 16'h0001);
            else
                add_request(OP_LOOKUP, 16'($urandom));
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (key_requests.size() != 0 || s_tvalid)
            @(posedge clk);
        while (lookup_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/skts_pkg.sv
rtl/skts_cell.sv
rtl/skts_chain.sv
rtl/sorted_key_table_search_insert.sv
bench/testbench.sv
